@@ rtl/poc_pkg.sv @@
// Shared types, constants and helpers of the passivity observer and controller.
package poc_pkg;

  localparam int unsigned MaxJ = 4;
  localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] CFG_SIDE   = 2'd0;
  localparam logic [1:0] CFG_PERIOD = 2'd1;
  localparam logic [1:0] CFG_MINSQ  = 2'd2;

  typedef struct packed {
    logic signed [31:0] vel_0;
    logic signed [31:0] vel_1;
    logic signed [31:0] vel_2;
    logic signed [31:0] vel_3;
    logic signed [31:0] frc_0;
    logic signed [31:0] frc_1;
    logic signed [31:0] frc_2;
    logic signed [31:0] frc_3;
    logic [47:0]        remote_energy;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_0;
    logic signed [31:0] out_1;
    logic signed [31:0] out_2;
    logic signed [31:0] out_3;
    logic [30:0]        gain;
    logic [47:0]        power_in;
    logic [47:0]        power_out;
    logic [47:0]        energy_in_total;
    logic [47:0]        energy_out_total;
    logic [47:0]        energy_dissipated;
  } out_item_t;

  // magnitude of a two's complement word (most negative gives 2^31)
  function automatic logic [31:0] mag32(input logic [31:0] x);
    logic [31:0] r;
    r = x[31] ? 32'(-x) : x;
    return r;
  endfunction

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [48:0] b);
    logic [49:0] s;
    s = {2'b0, a} + {1'b0, b};
    return (s > {2'b0, M48}) ? M48 : s[47:0];
  endfunction

endpackage

@@ rtl/poc_if.sv @@
// Valid/ready channels carrying input and result items.
interface poc_in_if;
  logic               valid;
  logic               ready;
  poc_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface poc_out_if;
  logic               valid;
  logic               ready;
  poc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/poc_mul.sv @@
// Shared 32x32 unsigned multiplier with registered product.
module poc_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);
  logic [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= {32'b0, a_i} * {32'b0, b_i};
  end

  assign prod_o = prod_q;
endmodule

@@ rtl/passivity_observer_controller.sv @@
// Time-domain passivity observer and controller, top level with sequencer.
// Paths: the result is offered straight away when the period is zero, after
//   power and energy when the balance is not negative, after the norm as well
//   when the norm is at or below the threshold, and after a correction (32-step
//   divide plus the multiplier passes) otherwise. Throughput: one item at a
//   time; the next item is taken the cycle after the result leaves.
// Reset (async, active low): energies zero, side leader, period and threshold
//   to their defaults, sequencer idle.
module passivity_observer_controller #(
  parameter int unsigned JOINTS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  poc_in_if.sink      in_i,
  poc_out_if.source   out_o
);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PWR   = 4'd1;   // v.f over the joints
  localparam logic [3:0] S_PSIGN = 4'd2;   // split into power in / out
  localparam logic [3:0] S_SCALE = 4'd3;   // power times period into an energy
  localparam logic [3:0] S_CMP   = 4'd4;   // energy balance
  localparam logic [3:0] S_NORM  = 4'd5;   // squared norm of x
  localparam logic [3:0] S_NCHK  = 4'd6;
  localparam logic [3:0] S_DEN   = 4'd7;   // period times norm
  localparam logic [3:0] S_DIV   = 4'd8;   // gain, one quotient bit a cycle
  localparam logic [3:0] S_CORR  = 4'd9;   // gain times x
  localparam logic [3:0] S_PD    = 4'd10;  // dissipated power
  localparam logic [3:0] S_OUT   = 4'd11;

  localparam logic [1:0] SEL_IN   = 2'd0;
  localparam logic [1:0] SEL_OUT  = 2'd1;
  localparam logic [1:0] SEL_DISS = 2'd2;

  logic [3:0]  state_q;
  logic [4:0]  cnt_q;
  logic [1:0]  sel_q;

  logic        side_q;
  logic [31:0] period_q, minsq_q;
  logic [47:0] acc_in_q, acc_out_q, acc_diss_q;

  logic [31:0] vm_q [poc_pkg::MaxJ];
  logic [31:0] fm_q [poc_pkg::MaxJ];
  logic        vn_q [poc_pkg::MaxJ];
  logic        fn_q [poc_pkg::MaxJ];
  logic [45:0] corr_q [poc_pkg::MaxJ];

  logic [47:0]        remote_q;
  logic signed [65:0] s_q;
  logic [47:0]        p_in_q, p_out_q, dp_q, def_q;
  logic [31:0]        scb_q;
  logic [64:0]        norm_q;
  logic [96:0]        wacc_q;
  logic [103:0]       rem_q;
  logic [127:0]       dsh_q;
  logic [30:0]        g_q;
  logic               sat_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic [1:0]  jl, jp;
  logic [31:0] xm_l;
  logic [47:0] sp;
  logic [96:0] wsum;
  logic [48:0] sres;
  logic [65:0] smag;
  logic [48:0] rhs;

  logic [31:0] vel_in [poc_pkg::MaxJ];
  logic [31:0] frc_in [poc_pkg::MaxJ];

  // incoming joints, unused ones read as zero
  always_comb begin
    vel_in[0] = in_i.data.vel_0;
    vel_in[1] = in_i.data.vel_1;
    vel_in[2] = in_i.data.vel_2;
    vel_in[3] = in_i.data.vel_3;
    frc_in[0] = in_i.data.frc_0;
    frc_in[1] = in_i.data.frc_1;
    frc_in[2] = in_i.data.frc_2;
    frc_in[3] = in_i.data.frc_3;
    for (int i = 0; i < poc_pkg::MaxJ; i++) begin
      if (i >= JOINTS) begin
        vel_in[i] = '0;
        frc_in[i] = '0;
      end
    end
  end

  assign jl = cnt_q[1:0];
  assign jp = cnt_q[1:0] - 2'd1;
  assign xm_l = side_q ? fm_q[jl] : vm_q[jl];

  always_comb begin
    unique case (sel_q)
      SEL_IN:  sp = p_in_q;
      SEL_OUT: sp = p_out_q;
      default: sp = dp_q;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_PWR: begin
        mul_a = vm_q[jl];
        mul_b = fm_q[jl];
      end
      S_SCALE: begin
        mul_a = (cnt_q == 5'd0) ? {8'b0, sp[23:0]} : {8'b0, sp[47:24]};
        mul_b = period_q;
      end
      S_NORM: begin
        mul_a = xm_l;
        mul_b = xm_l;
      end
      S_DEN: begin
        mul_a = period_q;
        mul_b = (cnt_q == 5'd0) ? norm_q[31:0] : norm_q[63:32];
      end
      S_CORR: begin
        mul_a = {1'b0, g_q};
        mul_b = xm_l;
      end
      S_PD: begin
        mul_a = {1'b0, g_q};
        mul_b = (cnt_q == 5'd0) ? norm_q[31:0] : norm_q[63:32];
      end
      default: ;
    endcase
  end

  poc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign wsum = wacc_q + {1'b0, prod, 32'b0};
  assign sres = 49'(({1'b0, prod[55:0]} + {25'b0, scb_q}) >> 8);
  assign smag = (s_q > 66'sd0) ? s_q : 66'(-s_q);
  assign rhs  = {1'b0, remote_q} + {1'b0, acc_diss_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      sel_q      <= SEL_IN;
      side_q     <= 1'b0;
      period_q   <= 32'd4294967;
      minsq_q    <= 32'd4295;
      acc_in_q   <= '0;
      acc_out_q  <= '0;
      acc_diss_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          poc_pkg::CFG_SIDE:   side_q   <= cfg_data_i[0];
          poc_pkg::CFG_PERIOD: period_q <= cfg_data_i;
          poc_pkg::CFG_MINSQ:  minsq_q  <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            for (int i = 0; i < poc_pkg::MaxJ; i++) begin
              corr_q[i] <= '0;
              vm_q[i]   <= poc_pkg::mag32(vel_in[i]);
              fm_q[i]   <= poc_pkg::mag32(frc_in[i]);
              vn_q[i]   <= vel_in[i][31];
              fn_q[i]   <= frc_in[i][31];
            end
            remote_q <= in_i.data.remote_energy;
            s_q      <= '0;
            p_in_q   <= '0;
            p_out_q  <= '0;
            g_q      <= '0;
            norm_q   <= '0;
            cnt_q    <= '0;
            state_q  <= (period_q == 32'd0) ? S_OUT : S_PWR;
          end
        end
        S_PWR: begin
          if (cnt_q != 5'd0) begin
            if (prod != 64'd0 && vn_q[jp] != fn_q[jp]) begin
              s_q <= s_q - $signed({2'b0, prod});
            end else begin
              s_q <= s_q + $signed({2'b0, prod});
            end
          end
          if (cnt_q == 5'd4) begin
            cnt_q   <= '0;
            state_q <= S_PSIGN;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_PSIGN: begin
          if (s_q > 66'sd0) begin
            p_in_q <= (|smag[65:56]) ? poc_pkg::M48 : smag[55:8];
          end else begin
            p_out_q <= (|smag[65:56]) ? poc_pkg::M48 : smag[55:8];
          end
          sel_q   <= SEL_IN;
          cnt_q   <= '0;
          state_q <= S_SCALE;
        end
        S_SCALE: begin
          // floor(p*t / 2^32) from two 24-bit slices of p
          if (cnt_q == 5'd1) begin
            scb_q <= prod[55:24];
          end
          if (cnt_q == 5'd2) begin
            cnt_q <= '0;
            unique case (sel_q)
              SEL_IN: begin
                acc_in_q <= poc_pkg::sat_add48(acc_in_q, sres);
                sel_q    <= SEL_OUT;
              end
              SEL_OUT: begin
                acc_out_q <= poc_pkg::sat_add48(acc_out_q, sres);
                state_q   <= S_CMP;
              end
              default: begin
                acc_diss_q <= poc_pkg::sat_add48(acc_diss_q, sres);
                state_q    <= S_OUT;
              end
            endcase
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_CMP: begin
          if ({1'b0, acc_out_q} > rhs) begin
            def_q   <= acc_out_q - remote_q - acc_diss_q;
            cnt_q   <= '0;
            state_q <= S_NORM;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_NORM: begin
          if (cnt_q != 5'd0) begin
            norm_q <= norm_q + {1'b0, prod};
          end
          if (cnt_q == 5'd4) begin
            cnt_q   <= '0;
            state_q <= S_NCHK;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_NCHK: begin
          state_q <= (norm_q > {33'b0, minsq_q}) ? S_DEN : S_OUT;
        end
        S_DEN: begin
          if (cnt_q == 5'd1) begin
            wacc_q <= {33'b0, prod} + (norm_q[64] ? {1'b0, period_q, 64'b0} : 97'd0);
          end
          if (cnt_q == 5'd2) begin
            dsh_q   <= {wsum, 31'b0};
            rem_q   <= {def_q, 56'b0};
            sat_q   <= 1'b0;
            cnt_q   <= '0;
            state_q <= S_DIV;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_DIV: begin
          // first step only tests for a quotient of 2^31 or more
          if ({24'b0, rem_q} >= dsh_q) begin
            if (cnt_q == 5'd0) begin
              sat_q <= 1'b1;
            end else if (!sat_q) begin
              rem_q <= rem_q - dsh_q[103:0];
              g_q[5'd31 - cnt_q] <= 1'b1;
            end
          end
          dsh_q <= dsh_q >> 1;
          if (cnt_q == 5'd31) begin
            if (sat_q) begin
              g_q <= '1;
            end
            cnt_q   <= '0;
            state_q <= S_CORR;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_CORR: begin
          if (cnt_q != 5'd0) begin
            corr_q[jp] <= prod[61:16];
          end
          if (cnt_q == 5'd4) begin
            cnt_q   <= '0;
            state_q <= S_PD;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_PD: begin
          if (cnt_q == 5'd1) begin
            wacc_q <= {33'b0, prod} + (norm_q[64] ? {2'b0, g_q, 64'b0} : 97'd0);
          end
          if (cnt_q == 5'd2) begin
            dp_q    <= (|wsum[96:72]) ? poc_pkg::M48 : wsum[71:24];
            sel_q   <= SEL_DISS;
            cnt_q   <= '0;
            state_q <= S_SCALE;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_OUT: begin
          if (out_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // corrected vector: y plus signed correction, saturated to Q16.16
  logic [31:0] outv [poc_pkg::MaxJ];

  always_comb begin
    logic signed [47:0] y, c, r;
    for (int i = 0; i < poc_pkg::MaxJ; i++) begin
      if (side_q) begin
        y = vn_q[i] ? -$signed({16'b0, vm_q[i]}) : $signed({16'b0, vm_q[i]});
        c = fn_q[i] ? -$signed({2'b0, corr_q[i]}) : $signed({2'b0, corr_q[i]});
      end else begin
        y = fn_q[i] ? -$signed({16'b0, fm_q[i]}) : $signed({16'b0, fm_q[i]});
        c = vn_q[i] ? -$signed({2'b0, corr_q[i]}) : $signed({2'b0, corr_q[i]});
      end
      r = y + c;
      if (r > 48'sh0000_7FFF_FFFF) begin
        outv[i] = 32'h7FFF_FFFF;
      end else if (r < -48'sh0000_8000_0000) begin
        outv[i] = 32'h8000_0000;
      end else begin
        outv[i] = r[31:0];
      end
    end
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = (state_q == S_OUT);

  assign out_o.data.out_0             = outv[0];
  assign out_o.data.out_1             = outv[1];
  assign out_o.data.out_2             = outv[2];
  assign out_o.data.out_3             = outv[3];
  assign out_o.data.gain              = g_q;
  assign out_o.data.power_in          = p_in_q;
  assign out_o.data.power_out         = p_out_q;
  assign out_o.data.energy_in_total   = acc_in_q;
  assign out_o.data.energy_out_total  = acc_out_q;
  assign out_o.data.energy_dissipated = acc_diss_q;

endmodule

@@ tb/sv/passivity_observer_controller_tb.sv @@
// Self-checking testbench for the passivity observer and controller.
`timescale 1ns / 100ps

module passivity_observer_controller_tb;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  poc_in_if  in_ch ();
  poc_out_if out_ch ();

  passivity_observer_controller u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // predictor copy of the configuration and energy accumulators
  logic        side_q;
  logic [31:0] period_q;
  logic [31:0] minsq_q;
  logic [47:0] e_in_q, e_out_q, e_diss_q;

  poc_pkg::in_item_t  pending_samples[$];
  poc_pkg::out_item_t expected_results[$];
  int        errors;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_off_cycles;
  bit        hold_off_req;

  // floor(p * t / 2^32)
  function automatic logic [47:0] energy_step(input logic [47:0] p, input logic [31:0] t);
    logic [79:0] prod;
    prod = 80'(p) * 80'(t);
    return prod[79:32];
  endfunction

  function automatic logic [47:0] acc_sat(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

  // one control sample: observe, then control
  function automatic poc_pkg::out_item_t predict_sample(input poc_pkg::in_item_t s);
    poc_pkg::out_item_t r;
    logic signed [31:0] v[4], f[4], x[4], y[4];
    logic signed [65:0] dot;
    logic [65:0] mag;
    logic [47:0] p_in, p_out, deficit, dp;
    logic [65:0] norm;
    logic [127:0] num, den, g128, pd;
    logic [30:0] g;
    logic [32:0] xm;
    logic [63:0] corr;
    logic signed [65:0] sum;
    logic [49:0] budget;
    v = '{s.vel_0, s.vel_1, s.vel_2, s.vel_3};
    f = '{s.frc_0, s.frc_1, s.frc_2, s.frc_3};
    p_in = '0;
    p_out = '0;
    g = '0;
    for (int i = 0; i < 4; i++) begin
      x[i] = side_q ? f[i] : v[i];
      y[i] = side_q ? v[i] : f[i];
    end
    if (period_q != 0) begin
      dot = '0;
      for (int i = 0; i < 4; i++) dot += 66'(v[i]) * 66'(f[i]);
      // Q32.32 magnitude, truncated to Q24.24
      mag = dot[65] ? 66'(-dot) : 66'(dot);
      mag = mag >> 8;
      if (!dot[65] && dot != 0) p_in = (mag > 66'hFFFF_FFFF_FFFF) ? '1 : mag[47:0];
      else p_out = (mag > 66'hFFFF_FFFF_FFFF) ? '1 : mag[47:0];
      e_in_q = acc_sat(e_in_q, energy_step(p_in, period_q));
      e_out_q = acc_sat(e_out_q, energy_step(p_out, period_q));
      budget = 50'(s.remote_energy) + 50'(e_diss_q);
      if (50'(e_out_q) > budget) begin
        deficit = 48'(50'(e_out_q) - budget);
        norm = '0;
        for (int i = 0; i < 4; i++) begin
          xm = x[i][31] ? 33'(-34'(x[i])) : 33'(x[i]);
          norm += 66'(xm) * 66'(xm);
        end
        if (norm > 66'(minsq_q)) begin
          num = 128'(deficit) << 56;
          den = 128'(period_q) * 128'(norm);
          g128 = num / den;
          g = (g128 > 128'h7FFF_FFFF) ? 31'h7FFF_FFFF : g128[30:0];
          pd = 128'(g) * 128'(norm);
          pd = pd >> 24;
          dp = (pd > 128'hFFFF_FFFF_FFFF) ? '1 : pd[47:0];
          e_diss_q = acc_sat(e_diss_q, energy_step(dp, period_q));
        end
      end
    end
    for (int i = 0; i < 4; i++) begin
      xm = x[i][31] ? 33'(-34'(x[i])) : 33'(x[i]);
      corr = (64'(g) * 64'(xm)) >> 16;
      sum = 66'(y[i]) + (x[i][31] ? -66'(corr) : 66'(corr));
      if (sum > 66'sd2147483647) sum = 66'sd2147483647;
      if (sum < -66'sd2147483648) sum = -66'sd2147483648;
      case (i)
        0: r.out_0 = sum[31:0];
        1: r.out_1 = sum[31:0];
        2: r.out_2 = sum[31:0];
        default: r.out_3 = sum[31:0];
      endcase
    end
    r.gain = g;
    r.power_in = p_in;
    r.power_out = p_out;
    r.energy_in_total = e_in_q;
    r.energy_out_total = e_out_q;
    r.energy_dissipated = e_diss_q;
    return r;
  endfunction

  // driver: offers items from the queue, predicts on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(predict_sample(in_ch.data));
        void'(pending_samples.pop_front());
      end
      if (!in_ch.valid || in_ch.ready) begin
        // next offer, taking the popped queue into account
        if (pending_samples.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pending_samples[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_off_cycles <= 0;
    end else if (hold_off_req && hold_off_cycles == 0) begin
      hold_off_cycles <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ch.ready <= (hold_off_cycles == 1);
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk_i) begin
    poc_pkg::out_item_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, out_ch.data);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.data !== want) begin
          errors++;
          $display("%0t: expected %h", $time, want);
          $display("%0t: actual   %h", $time, out_ch.data);
        end
      end
    end
  end

  function automatic logic [31:0] rand_joint();
    case ($urandom_range(5, 0))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(131072, 0)) - 65536);
      3: return 32'($signed($urandom_range(2048, 0)) - 1024);
      default: return $urandom();
    endcase
  endfunction

  function automatic poc_pkg::in_item_t rand_sample();
    poc_pkg::in_item_t s;
    s.vel_0 = rand_joint();
    s.vel_1 = rand_joint();
    s.vel_2 = rand_joint();
    s.vel_3 = rand_joint();
    s.frc_0 = rand_joint();
    s.frc_1 = rand_joint();
    s.frc_2 = rand_joint();
    s.frc_3 = rand_joint();
    case ($urandom_range(3, 0))
      0: s.remote_energy = '0;
      1: s.remote_energy = 48'hFFFF_FFFF_FFFF;
      2: s.remote_energy = 48'($urandom_range(1 << 20, 0));
      default: s.remote_energy = 48'({$urandom(), $urandom()});
    endcase
    return s;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      poc_pkg::CFG_SIDE:   side_q   = val[0];
      poc_pkg::CFG_PERIOD: period_q = val;
      default:             minsq_q  = val;
    endcase
  endtask

  // wait until everything sent has come back, then a latency margin
  task automatic drain();
    while (pending_samples.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic run_phase(input int n, input int idle, input int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int k = 0; k < n; k++) pending_samples.push_back(rand_sample());
    drain();
  endtask

  initial begin
    poc_pkg::in_item_t s;
    cfg_we_i = 1'b0;
    cfg_idx_i = poc_pkg::CFG_SIDE;
    cfg_data_i = '0;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_req = 1'b0;
    side_q = 1'b0;
    period_q = 32'd4294967;
    minsq_q = 32'd4295;
    e_in_q = '0;
    e_out_q = '0;
    e_diss_q = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, zero vectors, power both ways, deficits, big remote energy
    s = '0;
    pending_samples.push_back(s);
    s = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 48'h0};
    repeat (3) pending_samples.push_back(s);
    s = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 48'hFFFF_FFFF_FFFF};
    pending_samples.push_back(s);
    s = '{32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h1,
          32'hFFFF_0000, 32'h0001_0000, 32'h1, 32'h0, 48'h0};
    repeat (4) pending_samples.push_back(s);
    // tiny vector: norm below threshold
    s = '{32'h1, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 48'h0};
    repeat (2) pending_samples.push_back(s);
    drain();

    write_reg(poc_pkg::CFG_SIDE, 32'd1);
    write_reg(poc_pkg::CFG_PERIOD, 32'hFFFF_FFFF);
    write_reg(poc_pkg::CFG_MINSQ, 32'd0);
    run_phase(60, 0, 0);
    write_reg(poc_pkg::CFG_PERIOD, 32'd0);
    run_phase(15, 0, 0);
    write_reg(poc_pkg::CFG_SIDE, 32'd0);
    write_reg(poc_pkg::CFG_PERIOD, 32'd4294967);
    write_reg(poc_pkg::CFG_MINSQ, 32'hFFFF_FFFF);
    run_phase(80, 66, 0);
    write_reg(poc_pkg::CFG_MINSQ, 32'd4295);
    run_phase(80, 0, 66);
    write_reg(poc_pkg::CFG_SIDE, 32'd1);
    write_reg(poc_pkg::CFG_PERIOD, $urandom());
    write_reg(poc_pkg::CFG_MINSQ, $urandom());
    run_phase(80, 13, 13);

    // long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int k = 0; k < 40; k++) pending_samples.push_back(rand_sample());
    @(negedge clk_i);
    hold_off_req = 1'b1;
    @(negedge clk_i);
    hold_off_req = 1'b0;
    drain();

    write_reg(poc_pkg::CFG_SIDE, 32'd0);
    write_reg(poc_pkg::CFG_PERIOD, $urandom_range(32'h00FF_FFFF, 1));
    run_phase(150, 0, 0);

    if (errors == 0) begin
      $display("passivity_observer_controller: match");
    end else begin
      $display("passivity_observer_controller: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("passivity_observer_controller: mismatch");
    $finish;
  end

endmodule
